FILE: rtl/rids_pkg.sv
// ----------------------------------------------------------------------------
// rids_pkg
// shared constants and codes for the replay identifier set
// ----------------------------------------------------------------------------
package rids_pkg;

  localparam int DEPTH      = 256;
  localparam int WORDS      = 8;
  localparam int WORD_W     = 64;
  localparam int WSEL_W     = $clog2(WORDS);
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int ADDR_W     = SLOT_W + WSEL_W;
  localparam int CNT_W      = 9;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 2;

  localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CONSUME = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_FRESH     = 2'd0,
    ST_REPLAY    = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

endpackage

FILE: rtl/rids_if.sv
// ----------------------------------------------------------------------------
// rids channel interfaces
// request, result and capacity write channels with valid/ready
// ----------------------------------------------------------------------------
interface rids_req_if import rids_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] id_word0;
  logic [WORD_W-1:0] id_word1;
  logic [WORD_W-1:0] id_word2;
  logic [WORD_W-1:0] id_word3;
  logic [WORD_W-1:0] id_word4;
  logic [WORD_W-1:0] id_word5;
  logic [WORD_W-1:0] id_word6;
  logic [WORD_W-1:0] id_word7;

  modport source (output valid, req_type, id_word0, id_word1, id_word2, id_word3,
                  id_word4, id_word5, id_word6, id_word7, input ready);
  modport sink (input valid, req_type, id_word0, id_word1, id_word2, id_word3,
                id_word4, id_word5, id_word6, id_word7, output ready);
endinterface

interface rids_res_if import rids_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink (input valid, status, entry_count, output ready);
endinterface

interface rids_cfg_if import rids_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/replay_id_set_unit.sv
// ----------------------------------------------------------------------------
// replay_id_set_unit
// replay guard over a table of consumed 512-bit identifiers
// ----------------------------------------------------------------------------
// One request at a time. A check or consume scans the stored entries through
// one 64-bit comparator, one word per cycle from a table memory with a
// separate write port and registered read, and a fresh consume then writes the
// identifier word by word. A clear, or a request refused because the count is
// above the capacity, goes straight to the finish state, and a request on an
// empty table skips the scan. A stalled result holds the block in its last
// state until the output register is free. The result sits in an output
// register, so the next request is taken while it waits. The capacity register
// is to be written only while the block is idle; the block itself does not
// enforce this. A value above 256 acts as 256.
module replay_id_set_unit import rids_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rids_req_if.sink    req,
  rids_res_if.source  res,
  rids_cfg_if.sink    cfg
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_WRITE  = 6'b001000,
    S_FINISH = 6'b010000,
    S_SPARE  = 6'b100000
  } state_t;

  state_t state;

  logic [WORD_W-1:0] mem [DEPTH*WORDS];
  logic [WORD_W-1:0] rd_data;

  logic [CNT_W-1:0]  table_capacity;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  count;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] word [WORDS];
  status_t           status;

  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] last_addr;
  logic              issue_done;
  logic              cmp_valid;
  logic              cmp_last;
  logic [WSEL_W-1:0] cmp_sel;
  logic              match_run;
  logic              match_run_next;
  logic              hit;
  logic              issuing;
  logic [WSEL_W-1:0] wcnt;

  logic              res_valid;
  status_t           res_status;
  logic [CNT_W-1:0]  res_count;

  logic              accept;
  logic              out_free;
  logic              rotate;
  logic [CNT_W-1:0]  cap_sat;

  assign accept   = req.valid && req.ready;
  assign out_free = !res_valid || res.ready;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.entry_count = res_count;

  assign cap_sat   = (table_capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : table_capacity;
  assign last_addr = {SLOT_W'(count - CNT_W'(1)), {WSEL_W{1'b1}}};
  assign issuing   = (state == S_SCAN) && !issue_done;

  assign match_run_next = (cmp_sel == '0) ? (rd_data == word[0])
                                          : (match_run && (rd_data == word[0]));
  assign hit    = (state == S_SCAN) && cmp_valid && (cmp_sel == {WSEL_W{1'b1}}) &&
                  match_run_next;
  assign rotate = ((state == S_SCAN) && cmp_valid) || (state == S_WRITE);

  // table memory
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      mem[{count[SLOT_W-1:0], wcnt}] <= word[0];
    end
    rd_data <= mem[rd_addr];
  end

  // request words, rotated so the word in use is always at the head
  always_ff @(posedge clk) begin
    if (accept) begin
      req_type <= req.req_type;
      word[0]  <= req.id_word0;
      word[1]  <= req.id_word1;
      word[2]  <= req.id_word2;
      word[3]  <= req.id_word3;
      word[4]  <= req.id_word4;
      word[5]  <= req.id_word5;
      word[6]  <= req.id_word6;
      word[7]  <= req.id_word7;
      cap_eff  <= cap_sat;
    end else if (rotate) begin
      for (int i = 0; i < WORDS - 1; i++) begin
        word[i] <= word[i+1];
      end
      word[WORDS-1] <= word[0];
    end
  end

  // compare pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= issuing;
    end
    cmp_sel  <= rd_addr[WSEL_W-1:0];
    cmp_last <= (rd_addr == last_addr);
    if (cmp_valid) begin
      match_run <= match_run_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_capacity <= CNT_W'(256);
    end else if (cfg.valid && cfg.ready) begin
      table_capacity <= cfg.data;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_addr    <= '0;
      issue_done <= 1'b0;
      wcnt       <= '0;
      status     <= ST_FRESH;
      res_status <= ST_FRESH;
      res_count  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rd_addr    <= '0;
          issue_done <= 1'b0;
          wcnt       <= '0;
          if (accept) begin
            if (req.req_type == REQ_CLEAR) begin
              count  <= '0;
              status <= ST_FRESH;
              state  <= S_FINISH;
            end else if (count > cap_sat) begin
              status <= ST_MALFORMED;
              state  <= S_FINISH;
            end else if (count == '0) begin
              status <= ST_FRESH;
              state  <= S_DECIDE;
            end else begin
              status <= ST_FRESH;
              state  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issuing) begin
            if (rd_addr == last_addr) begin
              issue_done <= 1'b1;
            end else begin
              rd_addr <= rd_addr + ADDR_W'(1);
            end
          end
          if (hit) begin
            status <= ST_REPLAY;
            state  <= S_DECIDE;
          end else if (cmp_valid && cmp_last) begin
            status <= ST_FRESH;
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (req_type == REQ_CONSUME && status == ST_FRESH) begin
            if (count >= cap_eff) begin
              status <= ST_MALFORMED;
              state  <= S_FINISH;
            end else begin
              state <= S_WRITE;
            end
          end else begin
            state <= S_FINISH;
          end
        end
        S_WRITE: begin
          wcnt <= wcnt + WSEL_W'(1);
          if (wcnt == {WSEL_W{1'b1}}) begin
            count <= count + CNT_W'(1);
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            res_status <= status;
            res_count  <= count;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count never passes the table depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("stored count above depth");

  // count moves only by one step up or a clear
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) && (count != $past(count)) |->
      (count == $past(count) + CNT_W'(1)) || (count == '0))
    else $error("stored count jumped");

  // an entry is written only below the effective capacity
  a_write_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (count < cap_eff))
    else $error("write past capacity");

  // a loaded result leaves the block idle
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH) && out_free |=> (state == S_IDLE) && res_valid)
    else $error("result load without return to idle");

endmodule
